// ----- hw/rtl/avdr_pkg.sv -----
// Shared types and constants for the amplitude-driven varispeed resampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package avdr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PLAY_W    = 18;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_SENS   = 3'd1;
  localparam logic [2:0] REG_MIN    = 3'd2;
  localparam logic [2:0] REG_MAX    = 3'd3;
  localparam logic [2:0] REG_SMOOTH = 3'd4;

  localparam logic [15:0] THRESH_RST = 16'd1311;
  localparam logic [17:0] SENS_RST   = 18'd98304;
  localparam logic [16:0] MIN_RST    = 17'd39322;
  localparam logic [16:0] MAX_RST    = 17'd117965;
  localparam logic [15:0] SMOOTH_RST = 16'd7864;

  localparam logic [PLAY_W-1:0] UNITY_SPEED = 18'd65536;

  typedef struct packed {
    logic [15:0] thresh;
    logic [17:0] sens;
    logic [16:0] lo_speed;
    logic [16:0] hi_speed;
    logic [15:0] smooth;
  } avdr_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/avdr_hist_ram.sv -----
// History sample memory: one write port, two read ports, registered read data.
// Uses avdr_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module avdr_hist_ram
  import avdr_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire                        clk,
  input  wire                        we,
  input  wire  [AW-1:0]              waddr,
  input  wire  signed [SAMPLE_W-1:0] wdata,
  input  wire  [AW-1:0]              raddr0,
  input  wire  [AW-1:0]              raddr1,
  output logic signed [SAMPLE_W-1:0] rdata0,
  output logic signed [SAMPLE_W-1:0] rdata1
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/avdr_speed_unit.sv -----
// Frame-end speed update: reciprocal-multiply divide of twice the amplitude sum by
// FRAMES, target speed with clamps, smoothing step. Holds play_speed. Uses avdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avdr_speed_unit
  import avdr_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire  [$clog2(FRAMES)+15:0] amp_sum,
  input  avdr_cfg_t                 cfg,
  output logic [PLAY_W-1:0]         play_speed,
  output logic                      done
);

  localparam int SW   = $clog2(FRAMES) + 16;
  localparam int XW   = SW + 1;
  localparam int KS   = XW + $clog2(FRAMES);
  // ceil(2^KS / FRAMES): exact floor divide for any XW-bit dividend
  localparam logic [XW:0] RECIP =
    (XW+1)'(((64'd1 << KS) + 64'(FRAMES) - 64'd1) / 64'(FRAMES));

  typedef enum logic [5:0] {
    SP_IDLE = 6'b000001,
    SP_DIV  = 6'b000010,
    SP_MUL1 = 6'b000100,
    SP_TGT  = 6'b001000,
    SP_MUL2 = 6'b010000,
    SP_PLAY = 6'b100000
  } sp_state_t;

  sp_state_t         state_r, state_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [16:0]       q_r, q_nxt;
  logic              ge_r, ge_nxt;
  logic [34:0]       prod1_r, prod1_nxt;
  logic [20:0]       dabs_r, dabs_nxt;
  logic              dneg_r, dneg_nxt;
  logic [20:0]       mag_r, mag_nxt;
  logic [PLAY_W-1:0] play_r, play_nxt;

  logic [2*XW:0]     quot_prod;
  logic [16:0]       amp;
  logic [16:0]       excess;
  logic [19:0]       tgt, t1, t2;
  logic signed [20:0] diff;
  logic [36:0]       prod2;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    q_nxt     = q_r;
    ge_nxt    = ge_r;
    prod1_nxt = prod1_r;
    dabs_nxt  = dabs_r;
    dneg_nxt  = dneg_r;
    mag_nxt   = mag_r;
    play_nxt  = play_r;

    quot_prod = x_r * RECIP;
    amp    = q_r;
    excess = amp - {1'b0, cfg.thresh};
    tgt    = ge_r ? (20'd65536 + 20'(prod1_r[34:16])) : 20'd65536;
    t1     = (tgt < 20'(cfg.lo_speed)) ? 20'(cfg.lo_speed) : tgt;
    t2     = (t1 > 20'(cfg.hi_speed)) ? 20'(cfg.hi_speed) : t1;
    diff   = $signed({1'b0, t2}) - $signed({3'b000, play_r});
    prod2  = dabs_r * cfg.smooth;

    case (state_r)
      SP_IDLE: begin
        if (start) begin
          x_nxt     = {amp_sum, 1'b0};
          state_nxt = SP_DIV;
        end
      end
      SP_DIV: begin
        q_nxt     = quot_prod[KS+16:KS];
        state_nxt = SP_MUL1;
      end
      SP_MUL1: begin
        ge_nxt    = (amp >= {1'b0, cfg.thresh});
        prod1_nxt = excess * cfg.sens;
        state_nxt = SP_TGT;
      end
      SP_TGT: begin
        dneg_nxt  = diff[20];
        dabs_nxt  = diff[20] ? 21'(-diff) : 21'(diff);
        state_nxt = SP_MUL2;
      end
      SP_MUL2: begin
        mag_nxt   = prod2[36:16];
        state_nxt = SP_PLAY;
      end
      SP_PLAY: begin
        play_nxt  = dneg_r ? (play_r - mag_r[PLAY_W-1:0]) : (play_r + mag_r[PLAY_W-1:0]);
        state_nxt = SP_IDLE;
      end
      default: state_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
      play_r  <= UNITY_SPEED;
    end else begin
      state_r <= state_nxt;
      play_r  <= play_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    q_r     <= q_nxt;
    ge_r    <= ge_nxt;
    prod1_r <= prod1_nxt;
    dabs_r  <= dabs_nxt;
    dneg_r  <= dneg_nxt;
    mag_r   <= mag_nxt;
  end

  assign play_speed = play_r;
  assign done       = (state_r == SP_PLAY);

endmodule

`default_nettype wire

// ----- hw/rtl/avdr_interp.sv -----
// Linear interpolation datapath: registered product, then truncate toward
// zero and saturate. Uses avdr_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module avdr_interp
  import avdr_pkg::*;
(
  input  wire                        clk,
  input  wire                        load,
  input  wire  signed [SAMPLE_W-1:0] h0,
  input  wire  signed [SAMPLE_W-1:0] h1,
  input  wire  [15:0]                frac,
  output logic signed [SAMPLE_W-1:0] q
);

  logic signed [33:0]         prod_r;
  logic signed [SAMPLE_W-1:0] h0_r;
  logic signed [16:0]         dh;
  logic signed [34:0]         total;
  logic signed [34:0]         biased;
  logic signed [18:0]         shifted;

  assign dh = $signed({h1[15], h1}) - $signed({h0[15], h0});

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= dh * $signed({1'b0, frac});
      h0_r   <= h0;
    end
  end

  always_comb begin
    total   = $signed({{3{h0_r[15]}}, h0_r, 16'h0000}) + $signed({prod_r[33], prod_r});
    biased  = total[34] ? (total + 35'sd65535) : total;
    shifted = 19'(biased >>> 16);
    if (shifted > 19'sd32767) begin
      q = 16'sh7fff;
    end else if (shifted < -19'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = shifted[15:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/amplitude_driven_varispeed_resampler.sv -----
// Top level: APB register file, history ring pointers, frame sequencer.
// Instantiates avdr_hist_ram, avdr_speed_unit, avdr_interp; uses avdr_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------
//   input   | in_sample_in                            | in_valid/in_ready
//   result  | out_sample_out, out_last_of_frame       | out_valid/out_ready
//   config  | cfg_psel/penable/pwrite/paddr/pwdata    | APB, cfg_pready=1
//
// The frame's last sample starts the speed unit (divide, target and smoothing),
// then a setup step; each of the FRAMES results goes through the history memory
// read, multiply and round stages, and once the history holds at least FRAMES+2
// samples the frame ends with a trim step. Reset is synchronous; the history memory
// is not cleared. A stalled out_ready holds the sequencer; in_ready is low until
// the frame is delivered.
`timescale 1ns / 1ps
`default_nettype none

module amplitude_driven_varispeed_resampler
  import avdr_pkg::*;
#(
  parameter int FRAMES         = 64,
  parameter int HISTORY_FRAMES = 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_last_of_frame,
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire  [CFG_AW-1:0]          cfg_paddr,
  input  wire  [CFG_DW-1:0]          cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CAP = FRAMES * HISTORY_FRAMES;
  localparam int AW  = $clog2(CAP);
  localparam int CW  = $clog2(CAP + 1);
  localparam int FW  = $clog2(FRAMES);
  localparam int SW  = $clog2(FRAMES) + 16;
  localparam int PW  = AW + 17;
  localparam int IW  = PW - 16;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SPD   = 8'b00000010,
    ST_SETUP = 8'b00000100,
    ST_ADDR  = 8'b00001000,
    ST_DATA  = 8'b00010000,
    ST_CALC  = 8'b00100000,
    ST_OUT   = 8'b01000000,
    ST_TRIM  = 8'b10000000
  } st_t;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] x);
    logic [AW:0] y;
    y = (x >= (AW+1)'(CAP)) ? (x - (AW+1)'(CAP)) : x;
    return y[AW-1:0];
  endfunction

  // configuration
  avdr_cfg_t cfg_r;
  logic      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh   <= THRESH_RST;
      cfg_r.sens     <= SENS_RST;
      cfg_r.lo_speed <= MIN_RST;
      cfg_r.hi_speed <= MAX_RST;
      cfg_r.smooth   <= SMOOTH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_THRESH: cfg_r.thresh   <= cfg_pwdata[15:0];
        REG_SENS:   cfg_r.sens     <= cfg_pwdata[17:0];
        REG_MIN:    cfg_r.lo_speed <= cfg_pwdata[16:0];
        REG_MAX:    cfg_r.hi_speed <= cfg_pwdata[16:0];
        REG_SMOOTH: cfg_r.smooth   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_THRESH: cfg_prdata = 32'(cfg_r.thresh);
      REG_SENS:   cfg_prdata = 32'(cfg_r.sens);
      REG_MIN:    cfg_prdata = 32'(cfg_r.lo_speed);
      REG_MAX:    cfg_prdata = 32'(cfg_r.hi_speed);
      REG_SMOOTH: cfg_prdata = 32'(cfg_r.smooth);
      default:    cfg_prdata = '0;
    endcase
  end

  // state
  st_t             state_r, state_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [SW-1:0]   amp_sum_r, amp_sum_nxt;
  logic [FW-1:0]   fpos_r, fpos_nxt;
  logic [FW-1:0]   idx_r, idx_nxt;
  logic            pass_r, pass_nxt;
  logic            active_r, active_nxt;
  logic [15:0]     frac_r, frac_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic            out_last_r, out_last_nxt;

  logic                       in_acc;
  logic                       mem_we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr0, raddr1;
  logic signed [SAMPLE_W-1:0] rdata0, rdata1;
  logic [15:0]                abs_s;
  logic [16:0]                neg_s;
  logic                       spd_start, spd_done;
  logic [PLAY_W-1:0]          play_speed;
  logic                       interp_load;
  logic signed [SAMPLE_W-1:0] interp_q;

  logic [IW-1:0]   n_ext, n_m1, rp_int, i0, i1, pass_i, kk, excess;
  logic [PW-1:0]   endpos, rp_adv;

  assign in_acc = in_valid & in_ready;
  assign neg_s  = -$signed({in_sample_in[15], in_sample_in});
  assign abs_s  = in_sample_in[15] ? neg_s[15:0] : in_sample_in;
  assign waddr  = (count_r == CW'(CAP)) ? start_r
                                        : wrap((AW+1)'(start_r) + (AW+1)'(count_r));

  assign n_ext  = IW'(count_r);
  assign n_m1   = n_ext - IW'(1);
  assign endpos = {n_m1, 16'h0000};
  assign rp_int = rp_r[PW-1:16];
  assign i0     = (rp_int > n_m1) ? n_m1 : rp_int;
  assign i1     = ((i0 + IW'(1)) < n_ext) ? (i0 + IW'(1)) : i0;
  assign pass_i = n_ext - IW'(FRAMES) + IW'(idx_r);
  assign rp_adv = rp_r + PW'(play_speed);
  assign excess = (count_r > CW'(2 * FRAMES)) ? (n_ext - IW'(2 * FRAMES)) : '0;
  assign kk     = (rp_int < excess) ? rp_int : excess;

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = start_r;
    count_nxt      = count_r;
    rp_nxt         = rp_r;
    amp_sum_nxt    = amp_sum_r;
    fpos_nxt       = fpos_r;
    idx_nxt        = idx_r;
    pass_nxt       = pass_r;
    active_nxt     = active_r;
    frac_nxt       = frac_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    spd_start      = 1'b0;
    interp_load    = 1'b0;
    raddr0         = wrap((AW+1)'(start_r) + (AW+1)'(i0));
    raddr1         = wrap((AW+1)'(start_r) + (AW+1)'(i1));

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          mem_we = 1'b1;
          if (count_r == CW'(CAP)) begin
            start_nxt = wrap((AW+1)'(start_r) + (AW+1)'(1));
          end else begin
            count_nxt = count_r + CW'(1);
          end
          amp_sum_nxt = amp_sum_r + SW'(abs_s);
          if (fpos_r == FW'(FRAMES - 1)) begin
            spd_start   = 1'b1;
            amp_sum_nxt = '0;
            fpos_nxt    = '0;
            state_nxt   = ST_SPD;
          end else begin
            fpos_nxt = fpos_r + FW'(1);
          end
        end
      end
      ST_SPD: begin
        if (spd_done) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        active_nxt = (count_r >= CW'(FRAMES + 2));
        pass_nxt   = !(count_r >= CW'(FRAMES + 2));
        idx_nxt    = '0;
        if ((count_r >= CW'(FRAMES + 2)) && (rp_r > endpos)) begin
          rp_nxt = {n_ext - IW'(FRAMES + 1), 16'h0000};
        end
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (pass_r) begin
          // pass-through: both ports on the sample, zero fraction
          raddr0   = wrap((AW+1)'(start_r) + (AW+1)'(pass_i));
          raddr1   = wrap((AW+1)'(start_r) + (AW+1)'(pass_i));
          frac_nxt = '0;
        end else begin
          frac_nxt = rp_r[15:0];
        end
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        interp_load = 1'b1;
        state_nxt   = ST_CALC;
      end
      ST_CALC: begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = interp_q;
        out_last_nxt   = (idx_r == FW'(FRAMES - 1));
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (!pass_r) begin
            if (rp_adv >= endpos) begin
              rp_nxt   = endpos;
              pass_nxt = 1'b1;
            end else begin
              rp_nxt = rp_adv;
            end
          end
          if (idx_r == FW'(FRAMES - 1)) begin
            state_nxt = active_r ? ST_TRIM : ST_IDLE;
          end else begin
            idx_nxt   = idx_r + FW'(1);
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_TRIM: begin
        // drop whole samples behind the read position, keep two frames
        start_nxt = wrap((AW+1)'(start_r) + (AW+1)'(kk));
        count_nxt = count_r - CW'(kk);
        rp_nxt    = rp_r - {kk, 16'h0000};
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      count_r     <= '0;
      rp_r        <= '0;
      amp_sum_r   <= '0;
      fpos_r      <= '0;
      idx_r       <= '0;
      pass_r      <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      amp_sum_r   <= amp_sum_nxt;
      fpos_r      <= fpos_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r       <= frac_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_last_of_frame = out_last_r;

  avdr_hist_ram #(
    .DEPTH (CAP),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (waddr),
    .wdata  (in_sample_in),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  avdr_speed_unit #(
    .FRAMES (FRAMES)
  ) u_speed (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (spd_start),
    .amp_sum    (amp_sum_r + SW'(abs_s)),
    .cfg        (cfg_r),
    .play_speed (play_speed),
    .done       (spd_done)
  );

  avdr_interp u_interp (
    .clk  (clk),
    .load (interp_load),
    .h0   (rdata0),
    .h1   (rdata1),
    .frac (frac_r),
    .q    (interp_q)
  );

endmodule

`default_nettype wire
